@@ design/psps_pkg.sv @@
// shared types, constants and helpers of the periodic seven-point stencil
package psps_pkg;

    localparam int WEIGHT_BITS    = 16;
    localparam int EXTENT_BITS    = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int SLOT_BITS      = 2;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LENGTH      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_WEIGHT   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEIGHBOR_WEIGHT = 2'd3;

    localparam logic [EXTENT_BITS-1:0] ROW_LENGTH_RESET      = 7'd64;
    localparam logic [EXTENT_BITS-1:0] ROW_COUNT_RESET       = 7'd64;
    localparam logic [WEIGHT_BITS-1:0] CENTER_WEIGHT_RESET   = 16'd32768;
    localparam logic [WEIGHT_BITS-1:0] NEIGHBOR_WEIGHT_RESET = 16'd5461;

    typedef struct packed {
        logic [EXTENT_BITS-1:0] row_length;
        logic [EXTENT_BITS-1:0] row_count;
        logic [WEIGHT_BITS-1:0] center_weight;
        logic [WEIGHT_BITS-1:0] neighbor_weight;
    } psps_cfg_t;

    typedef struct packed {
        logic produce;
        logic plane_done;
    } psps_flags_t;

    localparam int FLAG_BITS = $bits(psps_flags_t);

    // bits of a position index for an extent of up to max
    function automatic int pos_bits(input int max);
        return (max > 1) ? $clog2(max) : 1;
    endfunction

    // command word: sample, x, x-1, x+1, y, y-1, y+1, three slots, flags
    function automatic int cmd_bits(input int sb, input int xw, input int yw);
        return sb + 3 * xw + 3 * yw + 3 * SLOT_BITS + FLAG_BITS;
    endfunction

endpackage

@@ design/periodic_seven_point_stencil_top.sv @@
// top level: config registers, front, command queue and back of the stencil
// an item reaches its result via the queue, stages 1 to 4 and the output register
// throughput: one item per cycle when not stalled; each of the six store taps has
//   its own ram copy, so each tap is one read port per cycle plus the shared write
// the first item of each frame and the items of the first two planes give no result
// reset clears position, rotation, queue and pipeline valid flags; config returns
//   to its defaults; plane stores are not cleared and hold data only once written
module periodic_seven_point_stencil_top
    import psps_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = 64,
    parameter int MAX_ROW_COUNT  = 64,
    parameter int SAMPLE_BITS    = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
    input  logic [CFG_DATA_BITS-1:0]               cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // frame_start
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // result_value, result_column, result_row
    output logic [((SAMPLE_BITS + 19) / 8) * 8-1:0] m_axis_tdata,
    // plane_done
    output logic                                   m_axis_tlast
);

    localparam int OUT_W    = ((SAMPLE_BITS + 19) / 8) * 8;
    localparam int CMD_BITS = cmd_bits(SAMPLE_BITS, pos_bits(MAX_ROW_LENGTH),
                                       pos_bits(MAX_ROW_COUNT));

    psps_cfg_t cfg_reg, cfg_next;

    logic                   push, q_full, q_valid, q_pop;
    logic [CMD_BITS-1:0]    cmd, q_data;
    logic [SAMPLE_BITS-1:0] result_value;
    logic [5:0]             result_column, result_row;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_LENGTH:      cfg_next.row_length      = cfg_data[EXTENT_BITS-1:0];
                REG_ROW_COUNT:       cfg_next.row_count       = cfg_data[EXTENT_BITS-1:0];
                REG_CENTER_WEIGHT:   cfg_next.center_weight   = cfg_data[WEIGHT_BITS-1:0];
                REG_NEIGHBOR_WEIGHT: cfg_next.neighbor_weight = cfg_data[WEIGHT_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_length      <= ROW_LENGTH_RESET;
            cfg_reg.row_count       <= ROW_COUNT_RESET;
            cfg_reg.center_weight   <= CENTER_WEIGHT_RESET;
            cfg_reg.neighbor_weight <= NEIGHBOR_WEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_axis_tready = !q_full;

    psps_front #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROW_COUNT  (MAX_ROW_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .sample      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .frame_start (s_axis_tuser),
        .push        (push),
        .cmd         (cmd)
    );

    psps_queue #(
        .WIDTH (CMD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_data),
        .valid (q_valid)
    );

    psps_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROW_COUNT  (MAX_ROW_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .result_value  (result_value),
        .result_column (result_column),
        .result_row    (result_row),
        .plane_done    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({result_row, result_column, result_value});

endmodule

@@ design/psps_ram.sv @@
// generic single-write, single-read ram with registered read data
module psps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/psps_queue.sv @@
// short command queue between the front and the back
module psps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign full  = (count_reg == NW'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = entry_reg[rd_ptr_reg];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ design/psps_front.sv @@
// front: accepts samples, tracks position and plane rotation, builds commands
module psps_front
    import psps_pkg::*;
#(
    parameter int SAMPLE_BITS    = 32,
    parameter int MAX_ROW_LENGTH = 64,
    parameter int MAX_ROW_COUNT  = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  psps_cfg_t               cfg,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [SAMPLE_BITS-1:0]  sample,
    input  logic                    frame_start,
    output logic                    push,
    output logic [cmd_bits(SAMPLE_BITS, pos_bits(MAX_ROW_LENGTH),
                           pos_bits(MAX_ROW_COUNT))-1:0] cmd
);

    localparam int XW = pos_bits(MAX_ROW_LENGTH);
    localparam int YW = pos_bits(MAX_ROW_COUNT);
    localparam int LW = $clog2(MAX_ROW_LENGTH + 1);
    localparam int CW = $clog2(MAX_ROW_COUNT + 1);

    logic [XW-1:0]        col_reg, col_next;
    logic [YW-1:0]        row_reg, row_next;
    logic [1:0]           held_reg, held_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;

    logic [LW-1:0]        len;
    logic [CW-1:0]        cnt;
    logic [XW-1:0]        x, xm, xp;
    logic [YW-1:0]        y, ym, yp;
    logic [1:0]           held;
    logic [SLOT_BITS-1:0] slot, mid, old;
    logic                 last_col, last_row;
    psps_flags_t          flags;

    function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] s);
        logic [SLOT_BITS-1:0] r;
        unique case (s)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            2'd2:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // extents: zero reads as one, above the maximum saturates
    always_comb
    begin
        if (cfg.row_length == '0)
            len = LW'(1);
        else if (32'(cfg.row_length) > MAX_ROW_LENGTH)
            len = LW'(MAX_ROW_LENGTH);
        else
            len = LW'(cfg.row_length);

        if (cfg.row_count == '0)
            cnt = CW'(1);
        else if (32'(cfg.row_count) > MAX_ROW_COUNT)
            cnt = CW'(MAX_ROW_COUNT);
        else
            cnt = CW'(cfg.row_count);
    end

    // frame start restarts position and rotation before the sample is taken
    always_comb
    begin
        x    = frame_start ? '0 : col_reg;
        y    = frame_start ? '0 : row_reg;
        held = frame_start ? '0 : held_reg;
        slot = frame_start ? '0 : slot_reg;

        last_col = (32'(x) + 32'd1) >= 32'(len);
        last_row = (32'(y) + 32'd1) >= 32'(cnt);

        xm = (x == '0) ? XW'(len - LW'(1)) : x - XW'(1);
        xp = last_col ? '0 : x + XW'(1);
        ym = (y == '0) ? YW'(cnt - CW'(1)) : y - YW'(1);
        yp = last_row ? '0 : y + YW'(1);

        old = next_slot(slot);
        mid = next_slot(old);

        flags.produce    = (held >= 2'd2);
        flags.plane_done = last_col && last_row;
    end

    assign push = in_valid && in_ready;
    assign cmd  = {flags, old, mid, slot, yp, ym, y, xp, xm, x, sample};

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        slot_next = slot_reg;
        if (push)
        begin
            col_next  = last_col ? '0 : x + XW'(1);
            row_next  = y;
            held_next = held;
            slot_next = slot;
            if (last_col)
            begin
                row_next = last_row ? '0 : y + YW'(1);
                if (last_row)
                begin
                    held_next = (held >= 2'd2) ? held : held + 2'd1;
                    slot_next = old;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
            slot_reg <= slot_next;
        end
    end

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg != 2'd3)
        else $error("plane slot out of range");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != 2'd3)
        else $error("plane count beyond two");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (push && frame_start && !(last_col && last_row))
            |=> (slot_reg == 2'd0 && held_reg == 2'd0))
        else $error("frame start did not restart rotation");

endmodule

@@ design/psps_back.sv @@
// back: plane store access, neighbor sum, weighting, rounding and saturation
module psps_back
    import psps_pkg::*;
#(
    parameter int SAMPLE_BITS    = 32,
    parameter int MAX_ROW_LENGTH = 64,
    parameter int MAX_ROW_COUNT  = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psps_cfg_t              cfg,
    input  logic                   q_valid,
    input  logic [cmd_bits(SAMPLE_BITS, pos_bits(MAX_ROW_LENGTH),
                           pos_bits(MAX_ROW_COUNT))-1:0] q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] result_value,
    output logic [5:0]             result_column,
    output logic [5:0]             result_row,
    output logic                   plane_done
);

    localparam int SB = SAMPLE_BITS;
    localparam int XW = pos_bits(MAX_ROW_LENGTH);
    localparam int YW = pos_bits(MAX_ROW_COUNT);
    localparam int AW = SLOT_BITS + YW + XW;
    localparam int RAM_DEPTH = 3 * (1 << (YW + XW));
    localparam int S2W = SB + 2;
    localparam int S3W = SB + 3;
    localparam int PCW = SB + WEIGHT_BITS + 1;
    localparam int PNW = S3W + WEIGHT_BITS + 1;
    localparam int TW  = PNW + 1;
    localparam int SHW = TW - WEIGHT_BITS;
    localparam logic [TW-1:0] ROUND = TW'(1) << (WEIGHT_BITS - 1);

    localparam int TAPS       = 6;
    localparam int TAP_OLD    = 0;
    localparam int TAP_UP     = 1;
    localparam int TAP_DOWN   = 2;
    localparam int TAP_LEFT   = 3;
    localparam int TAP_RIGHT  = 4;
    localparam int TAP_CENTER = 5;

    psps_flags_t          q_flags;
    logic [SLOT_BITS-1:0] q_old, q_mid, q_slot;
    logic [YW-1:0]        q_y, q_ym, q_yp;
    logic [XW-1:0]        q_x, q_xm, q_xp;
    logic [SB-1:0]        q_sample;

    logic          adv;
    logic [AW-1:0] rd_addr [TAPS];
    logic [SB-1:0] rd_data [TAPS];

    // stage 1: store read data arrives
    logic          v1_reg, pd1_reg;
    logic [SB-1:0] sample1_reg;
    logic [5:0]    col1_reg, row1_reg;
    // stage 2: partial neighbor sums
    logic                  v2_reg, pd2_reg;
    logic signed [S2W-1:0] a2_reg, b2_reg, a2_next, b2_next;
    logic signed [SB-1:0]  ctr2_reg;
    logic [5:0]            col2_reg, row2_reg;
    // stage 3: full neighbor sum
    logic                  v3_reg, pd3_reg;
    logic signed [S3W-1:0] nsum3_reg, nsum3_next;
    logic signed [SB-1:0]  ctr3_reg;
    logic [5:0]            col3_reg, row3_reg;
    // stage 4: weighted products
    logic                  v4_reg, pd4_reg;
    logic signed [PCW-1:0] pc4_reg, pc4_next;
    logic signed [PNW-1:0] pn4_reg, pn4_next;
    logic [5:0]            col4_reg, row4_reg;
    // output register
    logic          out_valid_reg, pd_out_reg;
    logic [SB-1:0] value_reg, value_next;
    logic [5:0]    col_out_reg, row_out_reg;

    logic [TW-1:0]  total;
    logic [SHW-1:0] shifted;
    logic [SHW-SB:0] top_bits;

    assign {q_flags, q_old, q_mid, q_slot, q_yp, q_ym, q_y, q_xp, q_xm, q_x, q_sample} = q_data;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    assign rd_addr[TAP_OLD]    = {q_old, q_y, q_x};
    assign rd_addr[TAP_UP]     = {q_mid, q_ym, q_x};
    assign rd_addr[TAP_DOWN]   = {q_mid, q_yp, q_x};
    assign rd_addr[TAP_LEFT]   = {q_mid, q_y, q_xm};
    assign rd_addr[TAP_RIGHT]  = {q_mid, q_y, q_xp};
    assign rd_addr[TAP_CENTER] = {q_mid, q_y, q_x};

    // one copy of the plane stores per tap, all written alike
    for (genvar t = 0; t < TAPS; t++)
    begin : g_tap
        psps_ram #(
            .WIDTH (SB),
            .DEPTH (RAM_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (q_pop),
            .waddr ({q_slot, q_y, q_x}),
            .wdata (q_sample),
            .re    (adv),
            .raddr (rd_addr[t]),
            .rdata (rd_data[t])
        );
    end

    always_comb
    begin
        a2_next = {{2{sample1_reg[SB-1]}}, sample1_reg}
                + {{2{rd_data[TAP_OLD][SB-1]}}, rd_data[TAP_OLD]}
                + {{2{rd_data[TAP_UP][SB-1]}}, rd_data[TAP_UP]};
        b2_next = {{2{rd_data[TAP_DOWN][SB-1]}}, rd_data[TAP_DOWN]}
                + {{2{rd_data[TAP_LEFT][SB-1]}}, rd_data[TAP_LEFT]}
                + {{2{rd_data[TAP_RIGHT][SB-1]}}, rd_data[TAP_RIGHT]};
        nsum3_next = {a2_reg[S2W-1], a2_reg} + {b2_reg[S2W-1], b2_reg};
        pc4_next = ctr3_reg * $signed({1'b0, cfg.center_weight});
        pn4_next = nsum3_reg * $signed({1'b0, cfg.neighbor_weight});
    end

    // round half up, drop the weight fraction, saturate
    always_comb
    begin
        total    = {{(TW - PCW){pc4_reg[PCW-1]}}, pc4_reg} + {pn4_reg[PNW-1], pn4_reg} + ROUND;
        shifted  = total[TW-1:WEIGHT_BITS];
        top_bits = shifted[SHW-1:SB-1];
        if ((&top_bits) || !(|top_bits))
            value_next = shifted[SB-1:0];
        else if (shifted[SHW-1])
            value_next = {1'b1, {(SB - 1){1'b0}}};
        else
            value_next = {1'b0, {(SB - 1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= q_pop && q_flags.produce;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sample1_reg <= q_sample;
            col1_reg    <= 6'(q_x);
            row1_reg    <= 6'(q_y);
            pd1_reg     <= q_flags.plane_done;

            a2_reg   <= a2_next;
            b2_reg   <= b2_next;
            ctr2_reg <= rd_data[TAP_CENTER];
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            pd2_reg  <= pd1_reg;

            nsum3_reg <= nsum3_next;
            ctr3_reg  <= ctr2_reg;
            col3_reg  <= col2_reg;
            row3_reg  <= row2_reg;
            pd3_reg   <= pd2_reg;

            pc4_reg  <= pc4_next;
            pn4_reg  <= pn4_next;
            col4_reg <= col3_reg;
            row4_reg <= row3_reg;
            pd4_reg  <= pd3_reg;

            value_reg   <= value_next;
            col_out_reg <= col4_reg;
            row_out_reg <= row4_reg;
            pd_out_reg  <= pd4_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = value_reg;
    assign result_column = col_out_reg;
    assign result_row    = row_out_reg;
    assign plane_done    = pd_out_reg;

endmodule

@@ test/stencil_checker.sv @@
// checker for the seven-point stencil: tracks the grid, predicts each result and compares
module stencil_checker
    import psps_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = 64,
    parameter int MAX_ROW_COUNT  = 64,
    parameter int SAMPLE_BITS    = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                cfg_data,
    input  logic                                    s_axis_tvalid,
    input  logic                                    s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,
    // frame_start
    input  logic                                    s_axis_tuser,
    input  logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // result_value, result_column, result_row
    input  logic [((SAMPLE_BITS + 19) / 8) * 8-1:0] m_axis_tdata,
    // plane_done
    input  logic                                    m_axis_tlast,
    output int                                      mismatches,
    output int                                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PLANE_CELLS = MAX_ROW_LENGTH * MAX_ROW_COUNT;
    localparam int     POS_BITS    = 6;
    localparam longint SAMPLE_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic [POS_BITS-1:0]    column;
        logic [POS_BITS-1:0]    row;
        logic                   done;
    } grid_point_t;

    longint                 grid_mem [3 * PLANE_CELLS];
    int                     col_pos;
    int                     row_pos;
    int                     full_planes;
    int                     cur_slot;
    logic [EXTENT_BITS-1:0] len_reg;
    logic [EXTENT_BITS-1:0] cnt_reg;
    logic [WEIGHT_BITS-1:0] center_w;
    logic [WEIGHT_BITS-1:0] neighbor_w;
    grid_point_t            due_points [$];

    function automatic int clamp_extent(input logic [EXTENT_BITS-1:0] v, input int max);
        if (v == 0)
            return 1;
        if (int'(v) > max)
            return max;
        return int'(v);
    endfunction

    function automatic int cell_at(input int slot, input int y, input int x);
        return slot * PLANE_CELLS + y * MAX_ROW_LENGTH + x;
    endfunction

    // take one sample into the grid; queue the point of the middle plane it completes
    task automatic advance_grid(input longint smp, input bit fs);
        int          len;
        int          cnt;
        int          x;
        int          y;
        int          mid;
        int          old;
        int          xm;
        int          xp;
        int          ym;
        int          yp;
        bit          last_col;
        bit          last_row;
        longint      nsum;
        longint      acc;
        longint      cwl;
        longint      nwl;
        grid_point_t pt;
        len = clamp_extent(len_reg, MAX_ROW_LENGTH);
        cnt = clamp_extent(cnt_reg, MAX_ROW_COUNT);
        if (fs)
        begin
            col_pos     = 0;
            row_pos     = 0;
            full_planes = 0;
            cur_slot    = 0;
        end
        x        = col_pos;
        y        = row_pos;
        last_col = (x + 1 >= len);
        last_row = (y + 1 >= cnt);
        if (full_planes >= 2)
        begin
            mid  = (cur_slot + 2) % 3;
            old  = (cur_slot + 1) % 3;
            xm   = (x == 0) ? len - 1 : x - 1;
            xp   = last_col ? 0 : x + 1;
            ym   = (y == 0) ? cnt - 1 : y - 1;
            yp   = last_row ? 0 : y + 1;
            nsum = smp + grid_mem[cell_at(old, y, x)]
                 + grid_mem[cell_at(mid, ym, x)] + grid_mem[cell_at(mid, yp, x)]
                 + grid_mem[cell_at(mid, y, xm)] + grid_mem[cell_at(mid, y, xp)];
            cwl  = center_w;
            nwl  = neighbor_w;
            // round half up, then floor shift by the weight fraction
            acc  = (cwl * grid_mem[cell_at(mid, y, x)] + nwl * nsum
                   + (longint'(1) <<< (WEIGHT_BITS - 1))) >>> WEIGHT_BITS;
            if (acc > SAMPLE_MAX)
                acc = SAMPLE_MAX;
            else if (acc < SAMPLE_MIN)
                acc = SAMPLE_MIN;
            pt.value  = acc[SAMPLE_BITS-1:0];
            pt.column = x[POS_BITS-1:0];
            pt.row    = y[POS_BITS-1:0];
            pt.done   = last_col && last_row;
            due_points.push_back(pt);
        end
        grid_mem[cell_at(cur_slot, y, x)] = smp;
        if (!last_col)
            col_pos = x + 1;
        else
        begin
            col_pos = 0;
            if (!last_row)
                row_pos = y + 1;
            else
            begin
                row_pos = 0;
                if (full_planes < 2)
                    full_planes++;
                cur_slot = (cur_slot + 1) % 3;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        grid_point_t got;
        grid_point_t want;
        if (!rst_n)
        begin
            due_points.delete();
            col_pos     = 0;
            row_pos     = 0;
            full_planes = 0;
            cur_slot    = 0;
            len_reg     = ROW_LENGTH_RESET;
            cnt_reg     = ROW_COUNT_RESET;
            center_w    = CENTER_WEIGHT_RESET;
            neighbor_w  = NEIGHBOR_WEIGHT_RESET;
            mismatches  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_LENGTH:      len_reg    = cfg_data[EXTENT_BITS-1:0];
                    REG_ROW_COUNT:       cnt_reg    = cfg_data[EXTENT_BITS-1:0];
                    REG_CENTER_WEIGHT:   center_w   = cfg_data[WEIGHT_BITS-1:0];
                    REG_NEIGHBOR_WEIGHT: neighbor_w = cfg_data[WEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_grid($signed(s_axis_tdata[SAMPLE_BITS-1:0]), s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value  = m_axis_tdata[SAMPLE_BITS-1:0];
                got.column = m_axis_tdata[SAMPLE_BITS +: POS_BITS];
                got.row    = m_axis_tdata[SAMPLE_BITS + POS_BITS +: POS_BITS];
                got.done   = m_axis_tlast;
                if (due_points.size() == 0)
                begin
                    $error("unexpected result at row %0d column %0d", got.row, got.column);
                    mismatches++;
                end
                else
                begin
                    want = due_points.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(want.value), $signed(got.value));
                        mismatches++;
                    end
                    if (got.column !== want.column)
                    begin
                        $error("result_column: expected %0d, got %0d", want.column, got.column);
                        mismatches++;
                    end
                    if (got.row !== want.row)
                    begin
                        $error("result_row: expected %0d, got %0d", want.row, got.row);
                        mismatches++;
                    end
                    if (got.done !== want.done)
                    begin
                        $error("plane_done: expected %0d, got %0d", want.done, got.done);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = due_points.size();
    end

endmodule

@@ test/tb_periodic_seven_point_stencil_top.sv @@
// testbench top for the periodic seven-point stencil: stimulus, handshakes and verdict
module tb_periodic_seven_point_stencil_top
    import psps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS    = 32;
    localparam int MAX_ROW_LENGTH = 64;
    localparam int MAX_ROW_COUNT  = 64;
    localparam int IN_BITS        = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS       = ((SAMPLE_BITS + 19) / 8) * 8;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_BITS-1:0]        s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_BITS-1:0]       m_axis_tdata;
    logic                      m_axis_tlast;
    int                        mismatches;
    int                        outstanding;
    int                        quiet_cycles;
    bit                        hold_request;
    logic [SAMPLE_BITS-1:0]    edge_samples [12];

    periodic_seven_point_stencil_top #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROW_COUNT  (MAX_ROW_COUNT),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    stencil_checker #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROW_COUNT  (MAX_ROW_COUNT),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
            2, 3:    return SAMPLE_BITS'($signed($urandom_range(0, 262143)) - 131072);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [SAMPLE_BITS-1:0] smp, input bit fs, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'(smp);
        s_axis_tuser  <= fs;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // stop offering, wait for every expected result, then for items still in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // watchdog: cycles with no handshake and no register write
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("periodic_seven_point_stencil_top test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, plus one long hold-off while the sender keeps going
    initial
    begin : result_side
        int stall;
        bit held;
        bit quiet;
        stall         = 0;
        held          = 1'b0;
        quiet         = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (hold_request && !held)
                begin
                    held  = 1'b1;
                    stall = RX_HOLD_CYCLES;
                end
                else
                begin
                    if ($urandom_range(0, 199) == 0)
                        quiet = !quiet;
                    stall = pick_gap(quiet);
                end
            end
        end
    end

    initial
    begin : stimulus
        int                     phase;
        int                     sent;
        int                     planes;
        int                     plane_cells;
        int                     len_eff;
        int                     cnt_eff;
        int                     p;
        int                     i;
        int                     r;
        bit                     fs;
        bit                     tx_quiet;
        logic [EXTENT_BITS-1:0] len_now;
        logic [EXTENT_BITS-1:0] cnt_now;
        logic [WEIGHT_BITS-1:0] cw_now;
        logic [WEIGHT_BITS-1:0] nw_now;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ROW_LENGTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        hold_request  = 1'b0;
        len_now       = ROW_LENGTH_RESET;
        cnt_now       = ROW_COUNT_RESET;
        edge_samples  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'hFFFF_8000};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // default extents: the start of a full-size plane gives nothing
        for (i = 0; i < 4; i++)
            send_item(random_sample(), i == 0, pick_gap(1'b0));
        settle();

        // 2x2 planes at full weights: extremes saturate at the positive limit
        write_reg(REG_ROW_LENGTH, CFG_DATA_BITS'(2));
        write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(2));
        write_reg(REG_CENTER_WEIGHT, 16'hFFFF);
        write_reg(REG_NEIGHBOR_WEIGHT, 16'hFFFF);
        cfg_we <= 1'b0;
        len_now = 7'd2;
        cnt_now = 7'd2;
        for (i = 0; i < 12; i++)
            send_item(edge_samples[i], i == 0, pick_gap(1'b0));
        // a frame start at a plane boundary drops the held planes
        send_item(32'h1234_5678, 1'b1, 0);
        send_item(32'hFEDC_BA98, 1'b0, 0);
        send_item(32'h0001_0000, 1'b0, 0);

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            r = $urandom_range(0, 9);
            if (phase == 0)
            begin
                len_now = EXTENT_BITS'($urandom_range(4, 8));
                cnt_now = EXTENT_BITS'($urandom_range(4, 8));
            end
            else
            begin
                case (r)
                    0:
                    begin
                        len_now = 7'd1;
                        cnt_now = 7'd1;
                    end
                    1:
                    begin
                        len_now = 7'd64;
                        cnt_now = EXTENT_BITS'($urandom_range(1, 2));
                    end
                    2:
                    begin
                        len_now = EXTENT_BITS'($urandom_range(1, 2));
                        cnt_now = 7'd64;
                    end
                    3:
                    begin
                        // zero extents behave as one
                        len_now = 7'd0;
                        cnt_now = EXTENT_BITS'($urandom_range(0, 3));
                    end
                    4:
                    begin
                        // oversized extents clamp to the maximum
                        len_now = EXTENT_BITS'($urandom_range(65, 127));
                        cnt_now = 7'd1;
                    end
                    5:
                    begin
                        len_now = 7'd1;
                        cnt_now = EXTENT_BITS'($urandom_range(65, 127));
                    end
                    default:
                    begin
                        len_now = EXTENT_BITS'($urandom_range(1, 8));
                        cnt_now = EXTENT_BITS'($urandom_range(1, 8));
                    end
                endcase
            end
            case ($urandom_range(0, 4))
                0:       cw_now = '0;
                1:       cw_now = '1;
                2:       cw_now = CENTER_WEIGHT_RESET;
                default: cw_now = WEIGHT_BITS'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       nw_now = '0;
                1:       nw_now = '1;
                2:       nw_now = NEIGHBOR_WEIGHT_RESET;
                default: nw_now = WEIGHT_BITS'($urandom);
            endcase
            // extents always go in together so the stream stays consistent
            write_reg(REG_ROW_LENGTH, CFG_DATA_BITS'(len_now));
            write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(cnt_now));
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_CENTER_WEIGHT, cw_now);
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_NEIGHBOR_WEIGHT, nw_now);
            cfg_we <= 1'b0;

            len_eff     = (len_now == 0) ? 1 : (len_now > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH
                        : int'(len_now);
            cnt_eff     = (cnt_now == 0) ? 1 : (cnt_now > MAX_ROW_COUNT) ? MAX_ROW_COUNT
                        : int'(cnt_now);
            plane_cells = len_eff * cnt_eff;
            planes      = (plane_cells >= 64) ? 3 : 3 + $urandom_range(0, 3);
            tx_quiet    = ($urandom_range(0, 3) == 0);
            for (p = 0; p < planes; p++)
            begin
                if (phase == 0 && p == 2)
                    hold_request = 1'b1;
                for (i = 0; i < plane_cells; i++)
                begin
                    fs = (p == 0 && i == 0) || ($urandom_range(0, 149) == 0);
                    send_item(random_sample(), fs, pick_gap(tx_quiet));
                    sent++;
                end
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        settle();
        if (mismatches == 0)
            $display("periodic_seven_point_stencil_top test passed");
        else
            $display("periodic_seven_point_stencil_top test failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/psps_pkg.sv
design/psps_ram.sv
design/psps_queue.sv
design/psps_front.sv
design/psps_back.sv
design/periodic_seven_point_stencil_top.sv
test/stencil_checker.sv
test/tb_periodic_seven_point_stencil_top.sv
